>>> design/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
`default_nettype none
package lpfd_pkg;

	localparam int unsigned HEADER_BYTES = 8;
	localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);
	localparam int unsigned LEN_W        = 21;
	localparam int unsigned CNT_W        = 16;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(8192);

	typedef enum logic [0:0] {
		KIND_PAYLOAD = 1'b0,
		KIND_REJECT  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data_byte;
		logic [15:0]      msg_type;
		logic [15:0]      route_id;
		logic [LEN_W-1:0] frame_len;
		logic             last;
		logic [CNT_W-1:0] frames_done;
		logic [CNT_W-1:0] errors_seen;
	} res_t;

endpackage
`default_nettype wire

>>> design/lpfd_ifs.sv
// Stream and configuration channel interfaces for the deframer.
`default_nettype none
interface lpfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpfd_res_if
	import lpfd_pkg::*;
	;
	logic valid;
	logic ready;
	res_t res;

	modport source (output valid, output res, input ready);
	modport sink   (input valid, input res, output ready);
endinterface

interface lpfd_cfg_if
	import lpfd_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] max_payload_len;

	modport source (output valid, output max_payload_len, input ready);
	modport sink   (input valid, input max_payload_len, output ready);
endinterface
`default_nettype wire

>>> design/lpfd_parser.sv
// Input register plus header/payload parse logic and frame state.
`default_nettype none
module lpfd_parser
	import lpfd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [7:0]       in_byte,
	output logic                  in_ready,
	input  wire logic [LEN_W-1:0] max_len,
	input  wire logic             adv,
	output logic                  res_valid,
	output res_t                  res
);

	logic                 vld_s1;
	logic [7:0]           byte_s1;
	logic                 in_header_q;
	logic [55:0]          hdr_shift_q;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [LEN_W-1:0]     pay_cnt_q;
	logic [LEN_W-1:0]     pay_len_q;
	logic [15:0]          type_q;
	logic [15:0]          route_q;
	logic [CNT_W-1:0]     frame_cnt_q;
	logic [CNT_W-1:0]     err_cnt_q;

	logic             process;
	logic             hdr_done;
	logic [31:0]      hdr_len;
	logic [15:0]      hdr_type;
	logic [15:0]      hdr_route;
	logic             bad_len;
	logic [LEN_W-1:0] sat_len;
	logic [LEN_W-1:0] pay_cnt_nxt;
	logic             fin;

	assign in_ready = !vld_s1 || adv;
	assign process  = vld_s1 && adv;

	assign hdr_done    = (hdr_cnt_q == HDR_CNT_W'(HEADER_BYTES - 1));
	assign hdr_len     = hdr_shift_q[31:0];
	assign hdr_type    = hdr_shift_q[47:32];
	assign hdr_route   = {byte_s1, hdr_shift_q[55:48]};
	assign bad_len     = (hdr_len == 32'd0) || (hdr_len > {{(32-LEN_W){1'b0}}, max_len});
	assign sat_len     = (hdr_len[31:LEN_W] != '0) ? {LEN_W{1'b1}} : hdr_len[LEN_W-1:0];
	assign pay_cnt_nxt = pay_cnt_q + LEN_W'(1);
	assign fin         = (pay_cnt_nxt >= pay_len_q);

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (process) begin
			if (in_header_q) begin
				if (hdr_done && bad_len) begin
					res_valid       = 1'b1;
					res.kind        = KIND_REJECT;
					res.msg_type    = hdr_type;
					res.route_id    = hdr_route;
					res.frame_len   = sat_len;
					res.last        = 1'b1;
					res.frames_done = frame_cnt_q;
					res.errors_seen = err_cnt_q + CNT_W'(1);
				end
			end else begin
				res_valid       = 1'b1;
				res.kind        = KIND_PAYLOAD;
				res.data_byte   = byte_s1;
				res.msg_type    = type_q;
				res.route_id    = route_q;
				res.frame_len   = pay_len_q;
				res.last        = fin;
				res.frames_done = fin ? frame_cnt_q + CNT_W'(1) : frame_cnt_q;
				res.errors_seen = err_cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q <= 1'b1;
			hdr_shift_q <= '0;
			hdr_cnt_q   <= '0;
			pay_cnt_q   <= '0;
			pay_len_q   <= '0;
			type_q      <= '0;
			route_q     <= '0;
			frame_cnt_q <= '0;
			err_cnt_q   <= '0;
		end else if (process) begin
			if (in_header_q) begin
				if (!hdr_done) begin
					hdr_shift_q <= {byte_s1, hdr_shift_q[55:8]};
					hdr_cnt_q   <= hdr_cnt_q + HDR_CNT_W'(1);
				end else begin
					hdr_shift_q <= '0;
					hdr_cnt_q   <= '0;
					pay_cnt_q   <= '0;
					if (bad_len) begin
						err_cnt_q <= err_cnt_q + CNT_W'(1);
						pay_len_q <= '0;
						type_q    <= '0;
						route_q   <= '0;
					end else begin
						in_header_q <= 1'b0;
						pay_len_q   <= hdr_len[LEN_W-1:0];
						type_q      <= hdr_type;
						route_q     <= hdr_route;
					end
				end
			end else if (fin) begin
				frame_cnt_q <= frame_cnt_q + CNT_W'(1);
				in_header_q <= 1'b1;
				pay_cnt_q   <= '0;
				pay_len_q   <= '0;
				type_q      <= '0;
				route_q     <= '0;
			end else begin
				pay_cnt_q <= pay_cnt_nxt;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/lpfd_out_reg.sv
// Result output register; frees up as soon as the sink takes its contents.
`default_nettype none
module lpfd_out_reg
	import lpfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_valid,
	input  wire res_t res,
	output logic      adv,
	output logic      out_valid,
	output res_t      out_res,
	input  wire logic out_ready
);

	logic valid_q;
	res_t res_q;

	assign adv       = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

>>> design/length_prefixed_frame_deframer.sv
// Top level of the length-prefixed frame deframer.
`default_nettype none
// Takes one stream byte per transfer and produces at most one result per
// byte, sustaining one byte per clock when the result sink keeps up. Each
// frame opens with an 8-byte header: 32-bit little-endian payload length,
// 16-bit type, 16-bit route. Header bytes give no result, except that a
// length of zero or above max_payload_len gives one reject result on the
// eighth byte (kind=1, length saturated to 21 bits, last=1). Each payload
// byte then comes out tagged with type, route and length; the final one has
// last=1. A byte waits in the input register until the result register can
// take a new entry; its result, if any, is held there until the sink accepts
// it. Ready toward the source drops only when the input register holds a
// byte, a result waits in the result register and the sink stalls.
// max_payload_len (reset 8192) should be written only while the block is
// idle; its channel is always ready.
module length_prefixed_frame_deframer
	import lpfd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	lpfd_byte_if.sink   in_ch,
	lpfd_res_if.source  out_ch,
	lpfd_cfg_if.sink    cfg
);

	logic [LEN_W-1:0] max_len_q;
	logic             adv;
	logic             res_valid;
	res_t             res;

	// config register: one write per transfer, never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg.valid) begin
			max_len_q <= cfg.max_payload_len;
		end
	end

	// input register, header/payload parse and frame state
	lpfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_byte   (in_ch.in_byte),
		.in_ready  (in_ch.ready),
		.max_len   (max_len_q),
		.adv       (adv),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register toward the sink
	lpfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.adv       (adv),
		.out_valid (out_ch.valid),
		.out_res   (out_ch.res),
		.out_ready (out_ch.ready)
	);

endmodule
`default_nettype wire
